// ----- hw/rtl/pmsfr_pkg.sv -----
package pmsfr_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int SUM_BYTES   = 30;
   localparam int MEAS_COUNT  = 12;
   localparam int FIELD_COUNT = 14;
   localparam int SEEN_W      = $clog2(FRAME_BYTES + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] HEADER_0 = 8'h42;
   localparam logic [7:0] HEADER_1 = 8'h4D;

   localparam logic [31:0] READ_INTERVAL_RESET = 32'd60000;
   localparam logic [15:0] WARMUP_RESET        = 16'd1000;
   localparam logic [15:0] READ_TIMEOUT_RESET  = 16'd3000;

   typedef logic [1:0]        status_type;
   typedef logic [3:0]        field_index_type;
   typedef logic [15:0]       word_type;
   typedef logic [SEEN_W-1:0] seen_type;

   localparam status_type STATUS_PENDING = 2'd0;
   localparam status_type STATUS_OK      = 2'd1;
   localparam status_type STATUS_FAIL    = 2'd2;

   localparam field_index_type VERSION_FIELD  = field_index_type'(MEAS_COUNT);
   localparam field_index_type CHECKSUM_FIELD = field_index_type'(FIELD_COUNT - 1);

   typedef struct packed {
      logic [MEAS_COUNT-1:0][15:0] meas;
      logic [7:0]                  version;
      word_type                    checksum;
   } frame_type;

   // One classified item handed from the front to the back
   typedef struct packed {
      status_type status;
      logic       enable;
      frame_type  frame;
   } job_type;

   function automatic word_type field_value(frame_type f, field_index_type idx);
      word_type v;
      if (idx < VERSION_FIELD) begin
         v = f.meas[idx];
      end else if (idx == VERSION_FIELD) begin
         v = {8'd0, f.version};
      end else begin
         v = f.checksum;
      end
      return v;
   endfunction

endpackage

// ----- hw/rtl/pmsfr_queue.sv -----
module pmsfr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/pmsfr_front.sv -----
module pmsfr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_cmd,
   input  logic [7:0]          req_data_byte,
   input  logic [31:0]         req_now_ms,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic                job_push,
   output pmsfr_pkg::job_type  job_data,
   input  logic                job_full
);

   localparam logic [1:0] PH_SLEEP = 2'd0;
   localparam logic [1:0] PH_WARM  = 2'd1;
   localparam logic [1:0] PH_READ  = 2'd2;

   localparam logic [1:0] REG_READ_INTERVAL = 2'd0;
   localparam logic [1:0] REG_WARMUP        = 2'd1;
   localparam logic [1:0] REG_READ_TIMEOUT  = 2'd2;

   localparam int NB = pmsfr_pkg::FRAME_BYTES;

   logic [1:0]               phase_ff, phase_in;
   logic [7:0]               window_ff [NB];
   logic [7:0]               shifted [NB];
   pmsfr_pkg::seen_type      seen_ff, seen_in, seen_inc;
   pmsfr_pkg::word_type      sum_ff, sum_in, sum_next, sum_add, sum_sub;
   logic [31:0]              last_read_ff, last_read_in;
   logic [31:0]              act_ff, act_in;
   logic                     enable_ff, enable_in;
   logic [31:0]              interval_ff;
   logic [15:0]              warmup_ff, timeout_ff;
   logic [31:0]              since_act, since_last;
   logic                     accept, shift_en, frame_ok;
   pmsfr_pkg::frame_type     frame;

   assign accept    = req_push && !job_full;
   assign req_full  = job_full;
   assign csr_ready = 1'b1;
   assign since_act  = req_now_ms - act_ff;
   assign since_last = req_now_ms - last_read_ff;

   always_comb begin
      for (int i = 0; i < NB - 1; i++) begin
         shifted[i] = window_ff[i + 1];
      end
      shifted[NB - 1] = req_data_byte;
   end

   // Running sum of window bytes 0..29: add the byte entering position 29 once it
   // came in after warm-up, subtract the byte leaving only after it was counted
   always_comb begin
      seen_inc = (seen_ff < pmsfr_pkg::seen_type'(NB)) ?
                 seen_ff + pmsfr_pkg::seen_type'(1) : seen_ff;
      sum_add  = (seen_ff >= pmsfr_pkg::seen_type'(2)) ?
                 {8'd0, window_ff[pmsfr_pkg::SUM_BYTES]} : '0;
      sum_sub  = (seen_ff == pmsfr_pkg::seen_type'(NB)) ? {8'd0, window_ff[0]} : '0;
      sum_next = sum_ff + sum_add - sum_sub;
      frame_ok = (seen_inc == pmsfr_pkg::seen_type'(NB)) &&
                 (shifted[0] == pmsfr_pkg::HEADER_0) &&
                 (shifted[1] == pmsfr_pkg::HEADER_1) &&
                 (sum_next == {shifted[NB - 2], shifted[NB - 1]});
      for (int i = 0; i < pmsfr_pkg::MEAS_COUNT; i++) begin
         frame.meas[i] = {shifted[4 + 2 * i], shifted[5 + 2 * i]};
      end
      frame.version  = shifted[28];
      frame.checksum = {shifted[NB - 2], shifted[NB - 1]};
   end

   always_comb begin
      phase_in        = phase_ff;
      seen_in         = seen_ff;
      sum_in          = sum_ff;
      last_read_in    = last_read_ff;
      act_in          = act_ff;
      enable_in       = enable_ff;
      shift_en        = 1'b0;
      job_data.status = pmsfr_pkg::STATUS_PENDING;
      if (accept) begin
         unique case (phase_ff)
            PH_WARM: begin
               if (since_act >= 32'(warmup_ff)) begin
                  phase_in = PH_READ;
                  seen_in  = '0;
                  sum_in   = '0;
               end
            end
            PH_READ: begin
               if (req_cmd) begin
                  shift_en = 1'b1;
                  seen_in  = seen_inc;
                  sum_in   = sum_next;
                  if (frame_ok) begin
                     enable_in       = 1'b0;
                     last_read_in    = req_now_ms;
                     phase_in        = PH_SLEEP;
                     job_data.status = pmsfr_pkg::STATUS_OK;
                  end
               end else if (since_act > 32'(timeout_ff)) begin
                  enable_in       = 1'b0;
                  last_read_in    = req_now_ms;
                  phase_in        = PH_SLEEP;
                  job_data.status = pmsfr_pkg::STATUS_FAIL;
               end
            end
            default: begin
               phase_in = PH_SLEEP;
               if (since_last >= interval_ff) begin
                  enable_in = 1'b1;
                  act_in    = req_now_ms;
                  phase_in  = PH_WARM;
               end
            end
         endcase
      end
      job_data.enable = enable_in;
      job_data.frame  = frame;
   end

   assign job_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SLEEP;
         seen_ff      <= '0;
         sum_ff       <= '0;
         last_read_ff <= '0;
         act_ff       <= '0;
         enable_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         last_read_ff <= last_read_in;
         act_ff       <= act_in;
         enable_ff    <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= pmsfr_pkg::READ_INTERVAL_RESET;
         warmup_ff   <= pmsfr_pkg::WARMUP_RESET;
         timeout_ff  <= pmsfr_pkg::READ_TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_READ_INTERVAL: interval_ff <= csr_data;
            REG_WARMUP:        warmup_ff   <= csr_data[15:0];
            REG_READ_TIMEOUT:  timeout_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < NB; i++) begin
            window_ff[i] <= shifted[i];
         end
      end
   end

endmodule

// ----- hw/rtl/pmsfr_back.sv -----
module pmsfr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_empty,
   input  pmsfr_pkg::job_type          job_data,
   output logic                        job_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output pmsfr_pkg::status_type       rsp_status,
   output logic                        rsp_sensor_enable,
   output pmsfr_pkg::field_index_type  rsp_field_index,
   output pmsfr_pkg::word_type         rsp_field_value,
   output logic                        rsp_last
);

   pmsfr_pkg::job_type          job_ff, job_in;
   logic                        busy_ff, busy_in;
   pmsfr_pkg::field_index_type  idx_ff, idx_in;
   logic                        out_valid_ff, out_valid_in;
   pmsfr_pkg::status_type       out_status_ff, out_status_in;
   logic                        out_enable_ff, out_enable_in;
   pmsfr_pkg::field_index_type  out_index_ff, out_index_in;
   pmsfr_pkg::word_type         out_value_ff, out_value_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_free, is_ok, emit_last;

   assign out_free = !out_valid_ff || rsp_pop;
   assign job_pop  = !busy_ff && !job_empty;
   assign is_ok    = (job_ff.status == pmsfr_pkg::STATUS_OK);
   assign emit_last = !is_ok || (idx_ff == pmsfr_pkg::CHECKSUM_FIELD);

   always_comb begin
      job_in        = job_ff;
      busy_in       = busy_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_enable_in = out_enable_ff;
      out_index_in  = out_index_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      if (job_pop) begin
         job_in  = job_data;
         busy_in = 1'b1;
         idx_in  = '0;
      end
      if (busy_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_status_in = job_ff.status;
         out_enable_in = job_ff.enable;
         out_index_in  = is_ok ? idx_ff : '0;
         out_value_in  = is_ok ? pmsfr_pkg::field_value(job_ff.frame, idx_ff) : '0;
         out_last_in   = emit_last;
         busy_in       = !emit_last;
         idx_in        = idx_ff + pmsfr_pkg::field_index_type'(1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      idx_ff        <= idx_in;
      out_status_ff <= out_status_in;
      out_enable_ff <= out_enable_in;
      out_index_ff  <= out_index_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_sensor_enable = out_enable_ff;
   assign rsp_field_index   = out_index_ff;
   assign rsp_field_value   = out_value_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ----- hw/rtl/pm_sensor_frame_reader.sv -----
// Channel   Direction  Handshake          Payload
// req_      in         push / full        cmd, data_byte, now_ms
// rsp_      out        empty / pop        status, sensor_enable, field_index,
//                                         field_value, last
// csr_      in         valid / ready      index (2 bit), data (32 bit)
//
// The front takes one item per cycle while the job queue has room, updating
// the timers, the byte window and a running checksum in that cycle.
// The back emits one result per cycle from its output register while popped:
// a valid frame takes a load and fourteen results, any other item a load and one.
// Reset is synchronous; the window has no reset and is read only once 32 bytes
// have been taken since warm-up. A stalled pop backs up the queue, then req_full.
module pm_sensor_frame_reader #(
   parameter int QUEUE_DEPTH = pmsfr_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_cmd,
   input  logic [7:0]                  req_data_byte,
   input  logic [31:0]                 req_now_ms,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_sensor_enable,
   output logic [3:0]                  rsp_field_index,
   output logic [15:0]                 rsp_field_value,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_data
);

   localparam int JOB_W = $bits(pmsfr_pkg::job_type);

   pmsfr_pkg::job_type  push_job, pop_job;
   logic [JOB_W-1:0]    push_vec, pop_vec;
   logic                job_push, job_full, job_pop, job_empty;

   pmsfr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_now_ms    (req_now_ms),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .job_push      (job_push),
      .job_data      (push_job),
      .job_full      (job_full)
   );

   assign push_vec = push_job;
   assign pop_job  = pmsfr_pkg::job_type'(pop_vec);

   pmsfr_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_vec),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_vec),
      .empty     (job_empty)
   );

   pmsfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_empty         (job_empty),
      .job_data          (pop_job),
      .job_pop           (job_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_sensor_enable (rsp_sensor_enable),
      .rsp_field_index   (rsp_field_index),
      .rsp_field_value   (rsp_field_value),
      .rsp_last          (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_run_advances: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && rsp_status == pmsfr_pkg::STATUS_OK && !rsp_last) |=>
      (!rsp_empty && rsp_status == pmsfr_pkg::STATUS_OK &&
       rsp_field_index == 4'($past(rsp_field_index) + 4'd1)))
      else $error("frame run did not advance to the next field");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != pmsfr_pkg::STATUS_OK) |->
      (rsp_last && rsp_field_index == 4'd0 && rsp_field_value == 16'd0))
      else $error("pending or failed result is not a single zero result");

   a_ok_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == pmsfr_pkg::STATUS_OK) |->
      (rsp_last == (rsp_field_index == pmsfr_pkg::CHECKSUM_FIELD)))
      else $error("frame run ends at the wrong field");

   a_end_drops_enable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != pmsfr_pkg::STATUS_PENDING) |-> !rsp_sensor_enable)
      else $error("sensor enable still high after a reading ended");
`endif

endmodule

// ----- test/pmsfr_reading_checker.sv -----
`timescale 1ns / 1ps

package pmsfr_tb_pkg;

   typedef enum logic [1:0] {
      REG_READ_INTERVAL = 2'd0,
      REG_WARMUP        = 2'd1,
      REG_READ_TIMEOUT  = 2'd2,
      REG_SPARE         = 2'd3
   } csr_reg_type;

endpackage

module pmsfr_reading_checker
   import pmsfr_pkg::*;
   import pmsfr_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_now_ms,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_sensor_enable,
   input  logic [3:0]  rsp_field_index,
   input  logic [15:0] rsp_field_value,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          readings_due
);

   typedef enum logic [1:0] {SLEEPING, WARMING, READING} reader_phase_type;

   typedef struct packed {
      status_type      status;
      logic            enable;
      field_index_type index;
      word_type        value;
      logic            last;
   } reading_type;

   reading_type expected_readings[$];

   logic [31:0]                 wake_gap_ms;
   logic [15:0]                 warmup_ms;
   logic [15:0]                 timeout_ms;
   reader_phase_type            phase;
   logic [FRAME_BYTES-1:0][7:0] window;
   seen_type                    seen;
   logic [31:0]                 last_read_ms;
   logic [31:0]                 active_since_ms;
   logic                        enable_level;
   int                          error_count = 0;

   function automatic logic frame_ok();
      logic [15:0] sum;
      sum = '0;
      for (int i = 0; i < SUM_BYTES; i++) sum += 16'(window[i]);
      return window[0] == HEADER_0 && window[1] == HEADER_1 &&
             sum == {window[FRAME_BYTES-2], window[FRAME_BYTES-1]};
   endfunction

   function automatic word_type frame_word(int idx);
      word_type w;
      if (idx < MEAS_COUNT) begin
         w = {window[4 + 2 * idx], window[5 + 2 * idx]};
      end else if (idx == MEAS_COUNT) begin
         w = {8'd0, window[SUM_BYTES - 2]};
      end else begin
         w = {window[FRAME_BYTES-2], window[FRAME_BYTES-1]};
      end
      return w;
   endfunction

   function automatic void queue_reading(status_type st, field_index_type idx, word_type val,
                                         logic lst);
      reading_type r;
      r = '{status: st, enable: enable_level, index: idx, value: val, last: lst};
      expected_readings.push_back(r);
   endfunction

   // Work out the results of one accepted item and advance the reader state
   function automatic void advance_reader(logic cmd, logic [7:0] b, logic [31:0] now);
      logic [31:0] since_active;
      since_active = now - active_since_ms;
      case (phase)
         WARMING: begin
            // the item that ends the warm-up does not take its byte
            if (since_active >= warmup_ms) begin
               phase = READING;
               seen  = '0;
            end
            queue_reading(STATUS_PENDING, '0, '0, 1'b1);
         end
         READING: begin
            if (cmd) begin
               window = {b, window[FRAME_BYTES-1:1]};
               if (seen < FRAME_BYTES) seen++;
            end
            if (cmd && seen >= FRAME_BYTES && frame_ok()) begin
               enable_level = 1'b0;
               last_read_ms = now;
               phase        = SLEEPING;
               for (int i = 0; i < FIELD_COUNT; i++) begin
                  queue_reading(STATUS_OK, field_index_type'(i), frame_word(i),
                                i == FIELD_COUNT - 1);
               end
            end else if (!cmd && since_active > timeout_ms) begin
               enable_level = 1'b0;
               last_read_ms = now;
               phase        = SLEEPING;
               queue_reading(STATUS_FAIL, '0, '0, 1'b1);
            end else begin
               queue_reading(STATUS_PENDING, '0, '0, 1'b1);
            end
         end
         default: begin
            phase = SLEEPING;
            if (now - last_read_ms >= wake_gap_ms) begin
               enable_level    = 1'b1;
               active_since_ms = now;
               phase           = WARMING;
            end
            queue_reading(STATUS_PENDING, '0, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         wake_gap_ms     = READ_INTERVAL_RESET;
         warmup_ms       = WARMUP_RESET;
         timeout_ms      = READ_TIMEOUT_RESET;
         phase           = SLEEPING;
         seen            = '0;
         last_read_ms    = '0;
         active_since_ms = '0;
         enable_level    = 1'b0;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_READ_INTERVAL: wake_gap_ms = csr_data;
               REG_WARMUP:        warmup_ms   = csr_data[15:0];
               REG_READ_TIMEOUT:  timeout_ms  = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            advance_reader(req_cmd, req_data_byte, req_now_ms);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: result with no item waiting (status %0h, index %0h, value %0h)",
                        $time, rsp_status, rsp_field_index, rsp_field_value);
               error_count++;
            end else begin
               want = expected_readings.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("sensor_enable", 32'(want.enable), 32'(rsp_sensor_enable));
               check_field("field_index", 32'(want.index), 32'(rsp_field_index));
               check_field("field_value", 32'(want.value), 32'(rsp_field_value));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
      end
      mismatches   <= error_count;
      readings_due <= expected_readings.size();
   end

endmodule

// ----- test/tb_pm_sensor_frame_reader.sv -----
`timescale 1ns / 1ps

module tb_pm_sensor_frame_reader;
   import pmsfr_pkg::*;
   import pmsfr_tb_pkg::*;

   localparam int ITEM_TARGET   = 380;
   localparam int PHASE_COUNT   = 5;
   localparam int IDLE_PCT      = 15;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 200000;

   typedef logic [FRAME_BYTES-1:0][7:0] byte_frame_type;
   typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_type;
   typedef enum {LEAD_NONE, LEAD_CUT, LEAD_SPOILED} lead_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_push          = 1'b0;
   logic        req_full;
   logic        req_cmd           = 1'b0;
   logic [7:0]  req_data_byte     = '0;
   logic [31:0] req_now_ms        = '0;
   logic        rsp_empty;
   logic        rsp_pop           = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_sensor_enable;
   logic [3:0]  rsp_field_index;
   logic [15:0] rsp_field_value;
   logic        rsp_last;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index         = REG_READ_INTERVAL;
   logic [31:0] csr_data          = '0;

   int mismatches;
   int readings_due;
   int items_sent  = 0;
   int cycle_count = 0;
   bit calm         = 1'b0;
   bit hold_request = 1'b0;

   // Stimulus-side view of time and of the settings, used to aim the sequences
   logic [31:0] now_ms       = '0;
   logic [31:0] last_end_ms  = '0;
   logic [31:0] active_ms    = '0;
   logic [31:0] cfg_interval = READ_INTERVAL_RESET;
   logic [15:0] cfg_warmup   = WARMUP_RESET;
   logic [15:0] cfg_timeout  = READ_TIMEOUT_RESET;

   pm_sensor_frame_reader uut (.*);

   pmsfr_reading_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(logic cmd, logic [7:0] b, logic [31:0] at_ms);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= b;
      req_now_ms    <= at_ms;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   // One received byte while reading, now and then preceded by an empty poll
   // that stays inside the timeout
   task automatic feed_byte(logic [7:0] b);
      if ($urandom_range(0, 99) < 8 && now_ms - active_ms <= cfg_timeout) begin
         send_item(1'b0, 8'($urandom_range(0, 255)), now_ms);
      end
      now_ms += $urandom_range(0, 2);
      send_item(1'b1, b, now_ms);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_READ_INTERVAL: cfg_interval = value;
         REG_WARMUP:        cfg_warmup   = value[15:0];
         REG_READ_TIMEOUT:  cfg_timeout  = value[15:0];
         default: ;
      endcase
   endtask

   task automatic drain_readings();
      req_push <= 1'b0;
      do @(posedge clock); while (readings_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic byte_frame_type make_frame(fill_type fill);
      byte_frame_type f;
      logic [15:0]    sum;
      sum  = '0;
      f[0] = HEADER_0;
      f[1] = HEADER_1;
      for (int i = 2; i < SUM_BYTES; i++) begin
         case (fill)
            FILL_ONES:  f[i] = 8'hFF;
            FILL_ZEROS: f[i] = 8'h00;
            default:    f[i] = 8'($urandom_range(0, 255));
         endcase
      end
      for (int i = 0; i < SUM_BYTES; i++) sum += 16'(f[i]);
      f[FRAME_BYTES-2] = sum[15:8];
      f[FRAME_BYTES-1] = sum[7:0];
      return f;
   endfunction

   // Sleep, wake, warm up, then read until a good frame or a timeout ends it
   task automatic run_reading_cycle();
      byte_frame_type good;
      byte_frame_type broken;
      fill_type       fill;
      logic [32:0]    reach;
      logic [31:0]    early;
      int             cut;
      int             spot;
      if (cfg_interval != 0 && $urandom_range(0, 1) == 1) begin
         early = cfg_interval - 1 -
                 $urandom_range(0, (cfg_interval > 1000) ? 1000 : cfg_interval - 1);
         send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   last_end_ms + early);
      end
      reach = {1'b0, cfg_interval} + 33'($urandom_range(0, 50));
      if (reach[32]) reach = {1'b0, cfg_interval};
      active_ms = last_end_ms + reach[31:0];
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), active_ms);
      if (cfg_warmup != 0) begin
         repeat ($urandom_range(0, 3)) begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      active_ms + $urandom_range(0, cfg_warmup - 1));
         end
      end
      now_ms = active_ms + cfg_warmup + $urandom_range(0, 5);
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), now_ms);

      repeat ($urandom_range(0, 8)) feed_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 5))
         0:       fill = FILL_ONES;
         1:       fill = FILL_ZEROS;
         default: fill = FILL_RANDOM;
      endcase
      good   = make_frame(fill);
      broken = good;
      case (lead_type'($urandom_range(0, 2)))
         LEAD_CUT: begin
            cut = $urandom_range(1, FRAME_BYTES - 1);
            for (int i = 0; i < cut; i++) feed_byte(good[i]);
         end
         LEAD_SPOILED: begin
            spot = $urandom_range(0, FRAME_BYTES - 1);
            broken[spot] = broken[spot] ^ 8'($urandom_range(1, 255));
            for (int i = 0; i < FRAME_BYTES; i++) feed_byte(broken[i]);
         end
         default: ;
      endcase

      if ($urandom_range(0, 99) < 70) begin
         for (int i = 0; i < FRAME_BYTES; i++) feed_byte(good[i]);
      end else begin
         if (now_ms - active_ms <= cfg_timeout) begin
            now_ms = active_ms + cfg_timeout + 1 + $urandom_range(0, 100);
         end
         send_item(1'b0, 8'($urandom_range(0, 255)), now_ms);
      end
      last_end_ms = now_ms;
   endtask

   // Receiver: random pops, no stalls while calm, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (calm) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_pm_sensor_frame_reader: FAIL");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: interval 60000, warm-up 1000, timeout 3000
      send_item(1'b0, 8'h00, 32'd0);          // empty poll while sleeping
      send_item(1'b1, 8'hFF, 32'd59999);      // byte while sleeping, one short
      send_item(1'b1, 8'h00, 32'd60000);      // wake exactly at the interval
      send_item(1'b1, 8'h42, 32'd60500);      // byte while warming
      send_item(1'b0, 8'h00, 32'd60999);      // empty poll while warming
      send_item(1'b1, 8'h4D, 32'd61000);      // ends warm-up, byte dropped
      send_item(1'b1, 8'hAA, 32'd61001);
      send_item(1'b0, 8'h00, 32'd63000);      // exactly at the timeout: pending
      send_item(1'b0, 8'h00, 32'd63001);      // one past: fail
      send_item(1'b0, 8'h00, 32'd123000);     // one short of the interval
      send_item(1'b1, 8'h55, 32'hFFFF_FFFF);  // wake at the top of the tick range
      send_item(1'b0, 8'h00, 32'd998);        // warm-up across the wrap
      send_item(1'b1, 8'h42, 32'd999);
      send_item(1'b0, 8'h00, 32'd3000);       // timeout across the wrap
      last_end_ms = 32'd3000;
      drain_readings();

      for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
         case (phase_no)
            0: write_reg(REG_SPARE, $urandom());
            1: begin
               calm = 1'b1;
               write_reg(REG_READ_INTERVAL, 32'd0);
               write_reg(REG_WARMUP, 32'd0);
               write_reg(REG_READ_TIMEOUT, 32'd0);
            end
            2: begin
               calm = 1'b0;
               write_reg(REG_READ_INTERVAL, 32'hFFFF_FFFF);
               write_reg(REG_WARMUP, 32'h0000_FFFF);
               write_reg(REG_READ_TIMEOUT, 32'h0000_FFFF);
            end
            3: begin
               // hold the result side so the block backs up onto its input
               hold_request = 1'b1;
               write_reg(REG_READ_INTERVAL, $urandom_range(0, 100000));
               write_reg(REG_WARMUP, $urandom_range(0, 2000));
               write_reg(REG_READ_TIMEOUT, $urandom_range(0, 5000));
            end
            default: begin
               write_reg(REG_READ_INTERVAL, $urandom());
               write_reg(REG_WARMUP, $urandom());
               write_reg(REG_READ_TIMEOUT, $urandom());
            end
         endcase
         csr_valid <= 1'b0;
         while (items_sent < ITEM_TARGET * (phase_no + 1) / PHASE_COUNT) run_reading_cycle();
         drain_readings();
      end

      if (mismatches == 0) begin
         $display("tb_pm_sensor_frame_reader: PASS");
      end else begin
         $display("tb_pm_sensor_frame_reader: FAIL");
      end
      $finish;
   end

endmodule
